### rtl/state_based_charge_integrator_macros.svh
// ----------------------------------------------------------------------------
// Charge integrator assertion macros
// Concurrent checks clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STATE_BASED_CHARGE_INTEGRATOR_MACROS_SVH
`define STATE_BASED_CHARGE_INTEGRATOR_MACROS_SVH

// same-cycle implication
`define SBCI_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sbci check failed");

// next-cycle implication
`define SBCI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sbci check failed");

`endif

### rtl/sbci_pkg.sv
// ----------------------------------------------------------------------------
// Charge integrator package
// Request kinds, register indexes, scale constants and unit status type.
// ----------------------------------------------------------------------------
package sbci_pkg;

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 24;
  localparam int CAP_BITS      = 20;
  localparam int ACC_BITS      = 64;
  localparam int OUT_BITS      = 32;
  localparam int CAP_NA_BITS   = 52;
  localparam int MIN_SCALE_BITS = 16;

  localparam logic [1:0] KIND_CHANGE  = 2'd0;
  localparam logic [1:0] KIND_QUERY   = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  localparam logic [1:0] MODE_IDLE = 2'd0;

  localparam logic [CFG_IDX_BITS-1:0] REG_IDLE_CUR   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ADV_CUR    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CONN_CUR   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_STREAM_CUR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CAPACITY   = 3'd4;

  localparam logic [31:0] IDLE_RESET_NA   = 32'd10000;
  localparam logic [31:0] ADV_RESET_NA    = 32'd25000;
  localparam logic [31:0] CONN_RESET_NA   = 32'd50000;
  localparam logic [31:0] STREAM_RESET_NA = 32'd1400000;
  localparam logic [CAP_BITS-1:0] CAPACITY_RESET_UAH = 20'd15000;

  localparam logic [ACC_BITS-1:0]       MS_PER_HOUR = 64'd3600000;
  localparam logic [31:0]               CAP_SCALE   = 32'd3600000000;
  localparam logic [MIN_SCALE_BITS-1:0] MS_PER_MIN  = 16'd60000;
  localparam logic [31:0]               LOW_DRAW_NA = 32'd1000;
  localparam logic [OUT_BITS-1:0]       ALL_ONES32  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

### rtl/sbci_serial_mul.sv
// ----------------------------------------------------------------------------
// Serial multiplier
// Shift-add, one multiplier bit per cycle; product held after done.
// ----------------------------------------------------------------------------
module sbci_serial_mul
  import sbci_pkg::*;
#(
  parameter int A_BITS = 24,
  parameter int B_BITS = 48
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic [A_BITS+B_BITS-1:0] product,
  output unit_sts_t                sts
);

  localparam int P_BITS   = A_BITS + B_BITS;
  localparam int CNT_BITS = $clog2(A_BITS + 1);

  logic [P_BITS-1:0]   prod_r;
  logic [B_BITS-1:0]   mcand_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [B_BITS:0]     upper_sum;

  assign upper_sum = {1'b0, prod_r[P_BITS-1:A_BITS]}
                   + (prod_r[0] ? {1'b0, mcand_r} : {(B_BITS+1){1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(A_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      prod_r  <= {{B_BITS{1'b0}}, a};
      mcand_r <= b;
    end else if (busy_r) begin
      prod_r <= {upper_sum, prod_r[A_BITS-1:1]};
    end
  end

  assign product  = prod_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### rtl/sbci_serial_div.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle; quotient held after done.
// ----------------------------------------------------------------------------
module sbci_serial_div
  import sbci_pkg::*;
#(
  parameter int W = 64
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic [W-1:0] quotient,
  output unit_sts_t    sts
);

  localparam int CNT_BITS = $clog2(W + 1);

  logic [W-1:0]        rem_r;
  logic [W-1:0]        quo_r;
  logic [W-1:0]        dvs_r;
  logic [CNT_BITS-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [W:0]          shifted;
  logic [W:0]          diff;
  logic                fits;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign fits    = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_BITS'(W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
        if (cnt_r == CNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], fits};
    end
  end

  assign quotient = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### rtl/state_based_charge_integrator.sv
// ----------------------------------------------------------------------------
// State-based charge integrator
// A request is taken only in the idle state; in_stall holds new requests until
// the result is loaded into the output register. The work is done by the serial
// multiplier (one current bit a cycle) and the 64-step serial dividers.
// Reset (synchronous, rst_n low): idle state, zero charge, default registers.
// ----------------------------------------------------------------------------
module state_based_charge_integrator
  import sbci_pkg::*;
#(
  parameter int TIME_BITS    = 48,
  parameter int CURRENT_BITS = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_kind,
  input  logic [1:0]               in_new_state,
  input  logic [TIME_BITS-1:0]     in_now_ms,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_power_state,
  output logic [OUT_BITS-1:0]      out_consumed_nah,
  output logic [OUT_BITS-1:0]      out_minutes_left,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

`include "state_based_charge_integrator_macros.svh"

  localparam int P_BITS   = CURRENT_BITS + TIME_BITS;
  localparam int EXT_BITS = (P_BITS > ACC_BITS) ? P_BITS : ACC_BITS + 1;
  localparam int CW_EXT   = (CURRENT_BITS > CFG_DATA_BITS) ? CURRENT_BITS : CFG_DATA_BITS;
  localparam int DVS_BITS = CURRENT_BITS + MIN_SCALE_BITS;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_MUL    = 6'b000010,
    S_PREP   = 6'b000100,
    S_LAUNCH = 6'b001000,
    S_DIV    = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [CURRENT_BITS-1:0] cur_r [4];
  logic [CAP_BITS-1:0]     capacity_r;
  logic [1:0]              mode_r;
  logic [TIME_BITS-1:0]    enter_r;
  logic [ACC_BITS-1:0]     acc_r;

  logic [1:0]              kind_r;
  logic [1:0]              req_r;
  logic [TIME_BITS-1:0]    now_r;
  logic [ACC_BITS-1:0]     total_r;
  logic [CAP_NA_BITS-1:0]  cap_r;
  logic [DVS_BITS-1:0]     dvs_r;
  logic                    exh_r;
  logic                    low_r;

  logic                    out_valid_r;
  logic [1:0]              out_state_r;
  logic [OUT_BITS-1:0]     out_nah_r;
  logic [OUT_BITS-1:0]     out_mins_r;

  logic                    in_acc;
  logic                    out_free;
  logic                    load;
  logic [CURRENT_BITS-1:0] cur_sel;
  logic [CW_EXT-1:0]       cfg_ext;

  logic [P_BITS-1:0]       mul_prod;
  unit_sts_t               mul_sts;
  logic [EXT_BITS-1:0]     prod_ext;
  logic [ACC_BITS-1:0]     prod_sat;
  logic [ACC_BITS:0]       sum_raw;
  logic [ACC_BITS-1:0]     sum_sat;

  logic                    div_start;
  logic [ACC_BITS-1:0]     cap_ext;
  logic [ACC_BITS-1:0]     nah_q;
  logic [ACC_BITS-1:0]     min_q;
  unit_sts_t               nah_sts;
  unit_sts_t               min_sts;

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign load      = (state_r == S_OUT) && out_free;
  assign div_start = (state_r == S_LAUNCH);
  assign cfg_ready = 1'b1;
  assign cur_sel   = cur_r[mode_r];
  assign cfg_ext   = CW_EXT'(cfg_data);
  assign cap_ext   = ACC_BITS'(cap_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_acc) state_nxt = S_MUL;
      S_MUL:    if (mul_sts.done) state_nxt = S_PREP;
      S_PREP:   state_nxt = S_LAUNCH;
      S_LAUNCH: state_nxt = S_DIV;
      S_DIV:    if (nah_sts.done) state_nxt = S_OUT;
      S_OUT:    if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r[0]   <= CURRENT_BITS'(IDLE_RESET_NA);
      cur_r[1]   <= CURRENT_BITS'(ADV_RESET_NA);
      cur_r[2]   <= CURRENT_BITS'(CONN_RESET_NA);
      cur_r[3]   <= CURRENT_BITS'(STREAM_RESET_NA);
      capacity_r <= CAPACITY_RESET_UAH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_IDLE_CUR:   cur_r[0]   <= cfg_ext[CURRENT_BITS-1:0];
        REG_ADV_CUR:    cur_r[1]   <= cfg_ext[CURRENT_BITS-1:0];
        REG_CONN_CUR:   cur_r[2]   <= cfg_ext[CURRENT_BITS-1:0];
        REG_STREAM_CUR: cur_r[3]   <= cfg_ext[CURRENT_BITS-1:0];
        REG_CAPACITY:   capacity_r <= cfg_data[CAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  sbci_serial_mul #(
    .A_BITS (CURRENT_BITS),
    .B_BITS (TIME_BITS)
  ) u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (in_acc),
    .a       (cur_sel),
    .b       (in_now_ms - enter_r),
    .product (mul_prod),
    .sts     (mul_sts)
  );

  assign prod_ext = EXT_BITS'(mul_prod);
  assign prod_sat = (|prod_ext[EXT_BITS-1:ACC_BITS]) ? {ACC_BITS{1'b1}}
                                                     : prod_ext[ACC_BITS-1:0];
  assign sum_raw  = {1'b0, acc_r} + {1'b0, prod_sat};
  assign sum_sat  = sum_raw[ACC_BITS] ? {ACC_BITS{1'b1}} : sum_raw[ACC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      enter_r <= '0;
      acc_r   <= '0;
    end else if (state_r == S_MUL && mul_sts.done) begin
      if (kind_r == KIND_RESTART) begin
        mode_r  <= MODE_IDLE;
        enter_r <= now_r;
        acc_r   <= '0;
      end else if (kind_r == KIND_CHANGE && req_r != mode_r) begin
        mode_r  <= req_r;
        enter_r <= now_r;
        acc_r   <= sum_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_kind;
      req_r  <= in_new_state;
      now_r  <= in_now_ms;
    end
    if (state_r == S_MUL && mul_sts.done) begin
      total_r <= (kind_r == KIND_RESTART) ? '0 : sum_sat;
    end
    if (state_r == S_PREP) begin
      cap_r <= {{(CAP_NA_BITS-CAP_BITS){1'b0}}, capacity_r}
             * {{(CAP_NA_BITS-32){1'b0}}, CAP_SCALE};
      dvs_r <= {{MIN_SCALE_BITS{1'b0}}, cur_sel}
             * {{CURRENT_BITS{1'b0}}, MS_PER_MIN};
    end
    if (state_r == S_LAUNCH) begin
      exh_r <= (total_r >= cap_ext);
      low_r <= (cur_sel < CURRENT_BITS'(LOW_DRAW_NA));
    end
  end

  sbci_serial_div #(
    .W (ACC_BITS)
  ) u_div_nah (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (total_r),
    .divisor  (MS_PER_HOUR),
    .quotient (nah_q),
    .sts      (nah_sts)
  );

  sbci_serial_div #(
    .W (ACC_BITS)
  ) u_div_min (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cap_ext - total_r),
    .divisor  (ACC_BITS'(dvs_r)),
    .quotient (min_q),
    .sts      (min_sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_state_r <= mode_r;
      out_nah_r   <= (|nah_q[ACC_BITS-1:OUT_BITS]) ? ALL_ONES32 : nah_q[OUT_BITS-1:0];
      if (exh_r) begin
        out_mins_r <= '0;
      end else if (low_r || (|min_q[ACC_BITS-1:OUT_BITS])) begin
        out_mins_r <= ALL_ONES32;
      end else begin
        out_mins_r <= min_q[OUT_BITS-1:0];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_power_state  = out_state_r;
  assign out_consumed_nah = out_nah_r;
  assign out_minutes_left = out_mins_r;

  `SBCI_ASSERT_NEXT(a_accept_blocks, in_acc, in_stall)
  `SBCI_ASSERT_SAME(a_mul_free_at_start, in_acc, !mul_sts.busy)
  `SBCI_ASSERT_SAME(a_div_lockstep, nah_sts.done || min_sts.done, nah_sts.done && min_sts.done)
  `SBCI_ASSERT_SAME(a_div_free_at_launch, div_start, !nah_sts.busy && !min_sts.busy)
  `SBCI_ASSERT_NEXT(a_exhausted_zero, load && exh_r, out_minutes_left == '0)

endmodule
